### rtl/frd_pkg.sv
// shared types and constants for the fastcgi record deframer
// no dependencies; used by frd_front, frd_queue, frd_back and the top level
package frd_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // record types and begin-request values
  localparam logic [7:0]  KIND_BEGIN     = 8'd1;
  localparam logic [7:0]  KIND_PARAMS    = 8'd4;
  localparam logic [7:0]  KIND_STDIN     = 8'd5;
  localparam logic [15:0] ROLE_RESPONDER = 16'd1;
  localparam logic [7:0]  FLAG_KEEP      = 8'd1;
  localparam logic [15:0] BEGIN_MIN_LEN  = 16'd8;

  // width of a decoded pair length (31 bits after masking)
  localparam int unsigned LEN_W = 31;

  // result event codes
  typedef enum logic [2:0] {
    EV_BEGIN       = 3'd0,
    EV_PAIR_LEN    = 3'd1,
    EV_NAME_BYTE   = 3'd2,
    EV_VALUE_BYTE  = 3'd3,
    EV_PARAMS_END  = 3'd4,
    EV_STDIN_BYTE  = 3'd5,
    EV_REQ_DONE    = 3'd6
  } frd_event_t;

  // classified operations handed from front to back
  typedef enum logic [2:0] {
    OP_BEGIN = 3'd0,
    OP_PARAM = 3'd1,
    OP_PEND  = 3'd2,
    OP_STDIN = 3'd3,
    OP_DONE  = 3'd4
  } frd_op_kind_t;

  typedef struct packed {
    frd_op_kind_t kind;
    logic [7:0]   data;
    logic [15:0]  id;
    logic         responder_ok;
    logic         keep_connection;
  } frd_op_t;

endpackage

### rtl/fastcgi_record_deframer_unit.sv
// path: an accepted byte's operation is registered in the queue, then in the result register
// throughput: one byte per clock; the pair decoder in the back end takes one
//   queued operation per cycle, so only a stalled result side drops in_tready
// reset: synchronous active-low rst_n clears record framing, the pair decoder,
//   the queue pointers and the result valid flag; no clearing pass is needed
// depends on frd_pkg, frd_front, frd_queue and frd_back
module fastcgi_record_deframer_unit #(
  parameter int unsigned QUEUE_DEPTH = frd_pkg::QUEUE_DEPTH  // 2 or more
) (
  input  logic        clk,
  input  logic        rst_n,
  // request byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] stream_byte
  // decoded events
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // [7:0] data_byte, [23:8] request_id,
                                   // [54:24] name_length, [85:55] value_length,
                                   // [86] responder_ok, [87] keep_connection,
                                   // [88] params_ok, [95:89] zero
  output logic        out_tlast,   // last_of_field
  output logic [2:0]  out_tuser    // [2:0] event_res
);

  localparam int unsigned LW = frd_pkg::LEN_W;

  // front to queue
  logic             f_valid;
  logic             f_ready;
  frd_pkg::frd_op_t f_op;

  // queue to back
  logic             q_valid;
  logic             q_ready;
  frd_pkg::frd_op_t q_op;

  // back result fields
  frd_pkg::frd_event_t b_event;
  logic [7:0]          b_data;
  logic [15:0]         b_id;
  logic [LW-1:0]       b_name_len;
  logic [LW-1:0]       b_value_len;
  logic                b_rok;
  logic                b_keep;
  logic                b_pok;

  // framing and byte classification
  frd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .op_valid  (f_valid),
    .op_ready  (f_ready),
    .op        (f_op)
  );

  // decouples framing from a stalled result side
  frd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_op    (f_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  // pair decoding and the result register
  frd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .op_valid         (q_valid),
    .op_ready         (q_ready),
    .op               (q_op),
    .res_valid        (out_tvalid),
    .res_ready        (out_tready),
    .res_event        (b_event),
    .res_data         (b_data),
    .res_last         (out_tlast),
    .res_id           (b_id),
    .res_name_len     (b_name_len),
    .res_value_len    (b_value_len),
    .res_responder_ok (b_rok),
    .res_keep         (b_keep),
    .res_params_ok    (b_pok)
  );

  // pack result fields, lowest field first
  assign out_tuser = b_event;
  assign out_tdata = {7'd0, b_pok, b_keep, b_rok, b_value_len, b_name_len, b_id, b_data};

endmodule

### rtl/frd_front.sv
// record framing front end: header parse, content and padding count
// classifies each byte into an operation; depends on frd_pkg
module frd_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [7:0]     in_tdata,   // [7:0] stream_byte
  output logic           op_valid,
  input  logic           op_ready,
  output frd_pkg::frd_op_t op
);

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_CONTENT = 3'b010,
    PH_PADDING = 3'b100
  } frd_phase_t;

  localparam logic [2:0] HDR_TYPE   = 3'd1;
  localparam logic [2:0] HDR_ID_HI  = 3'd2;
  localparam logic [2:0] HDR_ID_LO  = 3'd3;
  localparam logic [2:0] HDR_LEN_HI = 3'd4;
  localparam logic [2:0] HDR_LEN_LO = 3'd5;
  localparam logic [2:0] HDR_PAD    = 3'd6;
  localparam logic [2:0] HDR_LAST   = 3'd7;

  localparam logic [1:0] OFS_ROLE_HI = 2'd0;
  localparam logic [1:0] OFS_ROLE_LO = 2'd1;
  localparam logic [1:0] OFS_FLAGS   = 2'd2;
  localparam logic [1:0] OFS_DONE    = 2'd3;

  frd_phase_t  phase_r, phase_nxt;
  logic [2:0]  hdr_idx_r, hdr_idx_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] content_left_r, content_left_nxt;
  logic [7:0]  pad_left_r, pad_left_nxt;
  logic [1:0]  offset_r, offset_nxt;
  logic [15:0] role_r, role_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic        begin_long_r, begin_long_nxt;

  logic        has_op;
  logic        accept;
  logic        begin_ok;

  assign in_tready = op_ready;
  assign accept    = in_tvalid && op_ready;
  assign op_valid  = in_tvalid && has_op;

  always_comb begin
    phase_nxt        = phase_r;
    hdr_idx_nxt      = hdr_idx_r;
    kind_nxt         = kind_r;
    id_nxt           = id_r;
    content_left_nxt = content_left_r;
    pad_left_nxt     = pad_left_r;
    offset_nxt       = offset_r;
    role_nxt         = role_r;
    flags_nxt        = flags_r;
    begin_long_nxt   = begin_long_r;
    has_op           = 1'b0;
    begin_ok         = 1'b0;
    op.kind          = frd_pkg::OP_PARAM;
    op.data          = in_tdata;
    op.id            = id_r;
    op.responder_ok  = 1'b0;
    op.keep_connection = 1'b0;
    case (phase_r)
      PH_CONTENT: begin
        if (kind_r == frd_pkg::KIND_BEGIN) begin
          case (offset_r)
            OFS_ROLE_HI: role_nxt  = {in_tdata, role_r[7:0]};
            OFS_ROLE_LO: role_nxt  = {role_r[15:8], in_tdata};
            OFS_FLAGS:   flags_nxt = in_tdata;
            default: ;
          endcase
          if (offset_r != OFS_DONE) begin
            offset_nxt = offset_r + 2'd1;
          end
        end else if (kind_r == frd_pkg::KIND_PARAMS) begin
          has_op  = 1'b1;
          op.kind = frd_pkg::OP_PARAM;
        end else if (kind_r == frd_pkg::KIND_STDIN) begin
          has_op  = 1'b1;
          op.kind = frd_pkg::OP_STDIN;
        end
        content_left_nxt = content_left_r - 16'd1;
        if (content_left_nxt == 16'd0) begin
          if (kind_r == frd_pkg::KIND_BEGIN) begin
            begin_ok = begin_long_r && (role_nxt == frd_pkg::ROLE_RESPONDER);
            has_op   = 1'b1;
            op.kind  = frd_pkg::OP_BEGIN;
            op.responder_ok    = begin_ok;
            op.keep_connection = begin_ok && (flags_nxt == frd_pkg::FLAG_KEEP);
          end
          phase_nxt = (pad_left_r != 8'd0) ? PH_PADDING : PH_HEADER;
        end
      end
      PH_PADDING: begin
        pad_left_nxt = pad_left_r - 8'd1;
        if (pad_left_nxt == 8'd0) begin
          phase_nxt = PH_HEADER;
        end
      end
      PH_HEADER: begin
        case (hdr_idx_r)
          HDR_TYPE:   kind_nxt         = in_tdata;
          HDR_ID_HI:  id_nxt           = {in_tdata, id_r[7:0]};
          HDR_ID_LO:  id_nxt           = {id_r[15:8], in_tdata};
          HDR_LEN_HI: content_left_nxt = {in_tdata, content_left_r[7:0]};
          HDR_LEN_LO: content_left_nxt = {content_left_r[15:8], in_tdata};
          HDR_PAD:    pad_left_nxt     = in_tdata;
          default: ;
        endcase
        if (hdr_idx_r == HDR_LAST) begin
          hdr_idx_nxt    = 3'd0;
          begin_long_nxt = content_left_r >= frd_pkg::BEGIN_MIN_LEN;
          offset_nxt     = OFS_ROLE_HI;
          if (kind_r == frd_pkg::KIND_BEGIN) begin
            role_nxt  = 16'd0;
            flags_nxt = 8'd0;
          end
          if (content_left_r != 16'd0) begin
            phase_nxt = PH_CONTENT;
          end else begin
            // empty record: begin, params end or request complete
            if (kind_r == frd_pkg::KIND_BEGIN) begin
              has_op  = 1'b1;
              op.kind = frd_pkg::OP_BEGIN;
            end else if (kind_r == frd_pkg::KIND_PARAMS) begin
              has_op  = 1'b1;
              op.kind = frd_pkg::OP_PEND;
            end else if (kind_r == frd_pkg::KIND_STDIN) begin
              has_op  = 1'b1;
              op.kind = frd_pkg::OP_DONE;
            end
            phase_nxt = (pad_left_r != 8'd0) ? PH_PADDING : PH_HEADER;
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + 3'd1;
        end
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      hdr_idx_r      <= 3'd0;
      kind_r         <= 8'd0;
      id_r           <= 16'd0;
      content_left_r <= 16'd0;
      pad_left_r     <= 8'd0;
      offset_r       <= 2'd0;
      role_r         <= 16'd0;
      flags_r        <= 8'd0;
      begin_long_r   <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      hdr_idx_r      <= hdr_idx_nxt;
      kind_r         <= kind_nxt;
      id_r           <= id_nxt;
      content_left_r <= content_left_nxt;
      pad_left_r     <= pad_left_nxt;
      offset_r       <= offset_nxt;
      role_r         <= role_nxt;
      flags_r        <= flags_nxt;
      begin_long_r   <= begin_long_nxt;
    end
  end

  // content and padding phases always have bytes left to count
  a_content_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CONTENT) |-> (content_left_r != 16'd0))
    else $error("content phase with zero bytes left");

  a_pad_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PADDING) |-> (pad_left_r != 8'd0))
    else $error("padding phase with zero bytes left");

endmodule

### rtl/frd_queue.sv
// small fifo of classified operations between front and back
// depends on frd_pkg for the operation type
module frd_queue #(
  parameter int unsigned DEPTH = frd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  frd_pkg::frd_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output frd_pkg::frd_op_t pop_op
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frd_pkg::frd_op_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

endmodule

### rtl/frd_back.sv
// back end: name/value pair decoder and the registered result stage
// depends on frd_pkg for operation and event types
module frd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      op_valid,
  output logic                      op_ready,
  input  frd_pkg::frd_op_t          op,
  output logic                      res_valid,
  input  logic                      res_ready,
  output frd_pkg::frd_event_t       res_event,
  output logic [7:0]                res_data,
  output logic                      res_last,
  output logic [15:0]               res_id,
  output logic [frd_pkg::LEN_W-1:0] res_name_len,
  output logic [frd_pkg::LEN_W-1:0] res_value_len,
  output logic                      res_responder_ok,
  output logic                      res_keep,
  output logic                      res_params_ok
);

  localparam int unsigned LW = frd_pkg::LEN_W;

  typedef enum logic [5:0] {
    PP_NAME_LEN   = 6'b000001,
    PP_NAME_MORE  = 6'b000010,
    PP_VALUE_LEN  = 6'b000100,
    PP_VALUE_MORE = 6'b001000,
    PP_NAME       = 6'b010000,
    PP_VALUE      = 6'b100000
  } frd_pair_t;

  frd_pair_t   phase_r, phase_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [LW-1:0] pend_name_r, pend_name_nxt;
  logic [LW-1:0] pend_value_r, pend_value_nxt;
  logic [LW-1:0] left_r, left_nxt;

  logic        pop;
  logic        both;
  logic        out_valid_r;

  // result built this cycle
  logic                 r_vld;
  frd_pkg::frd_event_t  r_event;
  logic [7:0]           r_data;
  logic                 r_last;
  logic [LW-1:0]        r_name_len;
  logic [LW-1:0]        r_value_len;
  logic                 r_rok;
  logic                 r_keep;
  logic                 r_pok;

  frd_pkg::frd_event_t  out_event_r;
  logic [7:0]           out_data_r;
  logic                 out_last_r;
  logic [15:0]          out_id_r;
  logic [LW-1:0]        out_name_len_r;
  logic [LW-1:0]        out_value_len_r;
  logic                 out_rok_r;
  logic                 out_keep_r;
  logic                 out_pok_r;

  assign op_ready = !out_valid_r || res_ready;
  assign pop      = op_valid && op_ready;

  always_comb begin
    phase_nxt      = phase_r;
    seen_nxt       = seen_r;
    shift_nxt      = shift_r;
    pend_name_nxt  = pend_name_r;
    pend_value_nxt = pend_value_r;
    left_nxt       = left_r;
    both           = 1'b0;
    r_vld          = 1'b0;
    r_event        = frd_pkg::EV_BEGIN;
    r_data         = 8'd0;
    r_last         = 1'b0;
    r_name_len     = '0;
    r_value_len    = '0;
    r_rok          = 1'b0;
    r_keep         = 1'b0;
    r_pok          = 1'b0;
    if (pop) begin
      case (op.kind)
        frd_pkg::OP_BEGIN: begin
          r_vld   = 1'b1;
          r_event = frd_pkg::EV_BEGIN;
          r_rok   = op.responder_ok;
          r_keep  = op.keep_connection;
        end
        frd_pkg::OP_STDIN: begin
          r_vld   = 1'b1;
          r_event = frd_pkg::EV_STDIN_BYTE;
          r_data  = op.data;
        end
        frd_pkg::OP_DONE: begin
          r_vld   = 1'b1;
          r_event = frd_pkg::EV_REQ_DONE;
        end
        frd_pkg::OP_PEND: begin
          r_vld          = 1'b1;
          r_event        = frd_pkg::EV_PARAMS_END;
          r_pok          = (phase_r == PP_NAME_LEN);
          phase_nxt      = PP_NAME_LEN;
          seen_nxt       = 2'd0;
          shift_nxt      = 32'd0;
          pend_name_nxt  = '0;
          pend_value_nxt = '0;
          left_nxt       = '0;
        end
        frd_pkg::OP_PARAM: begin
          case (phase_r)
            PP_NAME_MORE, PP_VALUE_MORE: begin
              shift_nxt = {shift_r[23:0], op.data};
              seen_nxt  = (seen_r != 2'd0) ? seen_r - 2'd1 : 2'd0;
              if (seen_nxt == 2'd0) begin
                if (phase_r == PP_NAME_MORE) begin
                  pend_name_nxt = shift_nxt[LW-1:0];
                  phase_nxt     = PP_VALUE_LEN;
                end else begin
                  pend_value_nxt = shift_nxt[LW-1:0];
                  both           = 1'b1;
                end
              end
            end
            PP_VALUE_LEN: begin
              if (op.data[7]) begin
                shift_nxt = {24'd0, op.data};
                seen_nxt  = 2'd3;
                phase_nxt = PP_VALUE_MORE;
              end else begin
                pend_value_nxt = LW'(op.data);
                both           = 1'b1;
              end
            end
            PP_NAME, PP_VALUE: begin
              r_vld    = 1'b1;
              r_event  = (phase_r == PP_NAME) ? frd_pkg::EV_NAME_BYTE
                                              : frd_pkg::EV_VALUE_BYTE;
              r_data   = op.data;
              left_nxt = left_r - 1'b1;
              if (left_nxt == '0) begin
                r_last = 1'b1;
                if ((phase_r == PP_NAME) && (pend_value_r != '0)) begin
                  left_nxt  = pend_value_r;
                  phase_nxt = PP_VALUE;
                end else begin
                  phase_nxt = PP_NAME_LEN;
                end
              end
            end
            default: begin
              // waiting for a name length
              if (op.data[7]) begin
                shift_nxt = {24'd0, op.data};
                seen_nxt  = 2'd3;
                phase_nxt = PP_NAME_MORE;
              end else begin
                pend_name_nxt = LW'(op.data);
                phase_nxt     = PP_VALUE_LEN;
              end
            end
          endcase
          if (both) begin
            r_vld       = 1'b1;
            r_event     = frd_pkg::EV_PAIR_LEN;
            r_name_len  = pend_name_nxt;
            r_value_len = pend_value_nxt;
            if (pend_name_nxt != '0) begin
              left_nxt  = pend_name_nxt;
              phase_nxt = PP_NAME;
            end else if (pend_value_nxt != '0) begin
              left_nxt  = pend_value_nxt;
              phase_nxt = PP_VALUE;
            end else begin
              phase_nxt = PP_NAME_LEN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PP_NAME_LEN;
      seen_r       <= 2'd0;
      shift_r      <= 32'd0;
      pend_name_r  <= '0;
      pend_value_r <= '0;
      left_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      seen_r       <= seen_nxt;
      shift_r      <= shift_nxt;
      pend_name_r  <= pend_name_nxt;
      pend_value_r <= pend_value_nxt;
      left_r       <= left_nxt;
      out_valid_r  <= pop ? r_vld : (out_valid_r && !res_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && r_vld) begin
      out_event_r     <= r_event;
      out_data_r      <= r_data;
      out_last_r      <= r_last;
      out_id_r        <= op.id;
      out_name_len_r  <= r_name_len;
      out_value_len_r <= r_value_len;
      out_rok_r       <= r_rok;
      out_keep_r      <= r_keep;
      out_pok_r       <= r_pok;
    end
  end

  assign res_valid        = out_valid_r;
  assign res_event        = out_event_r;
  assign res_data         = out_data_r;
  assign res_last         = out_last_r;
  assign res_id           = out_id_r;
  assign res_name_len     = out_name_len_r;
  assign res_value_len    = out_value_len_r;
  assign res_responder_ok = out_rok_r;
  assign res_keep         = out_keep_r;
  assign res_params_ok    = out_pok_r;

  a_pend_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (op.kind == frd_pkg::OP_PEND)) |=> (phase_r == PP_NAME_LEN))
    else $error("pair decoder not cleared after params end");

  a_field_left: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PP_NAME) || (phase_r == PP_VALUE)) |-> (left_r != '0))
    else $error("name or value phase with no bytes left");

  a_len_more: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PP_NAME_MORE) || (phase_r == PP_VALUE_MORE)) |-> (seen_r != 2'd0))
    else $error("long length phase with no bytes pending");

endmodule

### test/frd_event_checker.sv
// event checker for the fastcgi record deframer: predicts the decoded event, if any, of
// every accepted request byte and compares it with the result channel
// depends on frd_pkg
module frd_event_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] stream_byte
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,   // [7:0] data_byte, [23:8] request_id,
                                   // [54:24] name_length, [85:55] value_length,
                                   // [86] responder_ok, [87] keep_connection,
                                   // [88] params_ok, [95:89] zero
  input  logic        out_tlast,   // last_of_field
  input  logic [2:0]  out_tuser,   // [2:0] event_res
  output int          error_count,
  output int          pending_count
);

  localparam int unsigned LW = frd_pkg::LEN_W;

  typedef enum logic [1:0] {PH_HEADER, PH_CONTENT, PH_PADDING} record_phase_t;
  typedef enum logic [2:0] {
    PP_NAME_LEN, PP_NAME_MORE, PP_VALUE_LEN, PP_VALUE_MORE, PP_NAME, PP_VALUE
  } pair_phase_t;

  typedef struct packed {
    frd_pkg::frd_event_t ev;
    logic [7:0]          data;
    logic                last;
    logic [15:0]         id;
    logic [LW-1:0]       name_len;
    logic [LW-1:0]       value_len;
    logic                rok;
    logic                keep;
    logic                pok;
    logic [6:0]          spare;
  } decoded_ev_t;

  // record framing
  record_phase_t    rec_ph;
  logic [2:0]       hdr_idx;
  logic [7:0]       rec_kind;
  logic [15:0]      cur_id;
  logic [15:0]      content_left;
  logic [7:0]       pad_left;
  logic [1:0]       content_off;
  logic [15:0]      role_word;
  logic [7:0]       flags_byte;
  logic             begin_long;
  // pair decoder
  pair_phase_t      pair_st;
  logic [1:0]       len_seen;
  logic [31:0]      len_shift;
  logic [LW-1:0]    pend_name;
  logic [LW-1:0]    pend_value;
  logic [LW-1:0]    field_left;

  decoded_ev_t expected_events[$];
  int          mismatches = 0;
  bit          has_ev;
  decoded_ev_t next_ev;

  task automatic clear_pairs();
    pair_st    = PP_NAME_LEN;
    len_seen   = '0;
    len_shift  = '0;
    pend_name  = '0;
    pend_value = '0;
    field_left = '0;
  endtask

  task automatic reset_predictor();
    rec_ph       = PH_HEADER;
    hdr_idx      = '0;
    rec_kind     = '0;
    cur_id       = '0;
    content_left = '0;
    pad_left     = '0;
    content_off  = '0;
    role_word    = '0;
    flags_byte   = '0;
    begin_long   = 1'b0;
    clear_pairs();
  endtask

  task automatic begin_result(inout decoded_ev_t r);
    r.ev   = frd_pkg::EV_BEGIN;
    r.rok  = begin_long && role_word == frd_pkg::ROLE_RESPONDER;
    r.keep = r.rok && flags_byte == frd_pkg::FLAG_KEEP;
  endtask

  // one params content byte through the name/value decoder
  task automatic decode_param(input logic [7:0] b, output bit got, inout decoded_ev_t r);
    bit lens_done;
    lens_done = 1'b0;
    got = 1'b0;
    case (pair_st)
      PP_NAME_MORE, PP_VALUE_MORE: begin
        len_shift = {len_shift[23:0], b};
        if (len_seen != 0) len_seen = len_seen - 1'b1;
        if (len_seen == 0) begin
          if (pair_st == PP_NAME_MORE) begin
            pend_name = len_shift[LW-1:0];
            pair_st = PP_VALUE_LEN;
          end else begin
            pend_value = len_shift[LW-1:0];
            lens_done = 1'b1;
          end
        end
      end
      PP_VALUE_LEN: begin
        if (b[7]) begin
          len_shift = {24'd0, b};
          len_seen = 2'd3;
          pair_st = PP_VALUE_MORE;
        end else begin
          pend_value = {23'd0, b};
          lens_done = 1'b1;
        end
      end
      PP_NAME, PP_VALUE: begin
        if (pair_st == PP_NAME) r.ev = frd_pkg::EV_NAME_BYTE;
        else r.ev = frd_pkg::EV_VALUE_BYTE;
        r.data = b;
        field_left = field_left - 1'b1;
        if (field_left == 0) begin
          r.last = 1'b1;
          if (pair_st == PP_NAME && pend_value != 0) begin
            field_left = pend_value;
            pair_st = PP_VALUE;
          end else begin
            pair_st = PP_NAME_LEN;
          end
        end
        got = 1'b1;
      end
      default: begin
        if (b[7]) begin
          len_shift = {24'd0, b};
          len_seen = 2'd3;
          pair_st = PP_NAME_MORE;
        end else begin
          pend_name = {23'd0, b};
          pair_st = PP_VALUE_LEN;
        end
      end
    endcase
    // both lengths known
    if (lens_done) begin
      r.ev = frd_pkg::EV_PAIR_LEN;
      r.name_len = pend_name;
      r.value_len = pend_value;
      if (pend_name != 0) begin
        field_left = pend_name;
        pair_st = PP_NAME;
      end else if (pend_value != 0) begin
        field_left = pend_value;
        pair_st = PP_VALUE;
      end else begin
        pair_st = PP_NAME_LEN;
      end
      got = 1'b1;
    end
  endtask

  task automatic predict_step(input logic [7:0] b, output bit got, output decoded_ev_t r);
    r = '0;
    got = 1'b0;
    case (rec_ph)
      PH_CONTENT: begin
        if (rec_kind == frd_pkg::KIND_BEGIN) begin
          case (content_off)
            2'd0: role_word[15:8] = b;
            2'd1: role_word[7:0] = b;
            2'd2: flags_byte = b;
            default: ;
          endcase
          if (content_off != 2'd3) content_off = content_off + 1'b1;
        end else if (rec_kind == frd_pkg::KIND_PARAMS) begin
          decode_param(b, got, r);
        end else if (rec_kind == frd_pkg::KIND_STDIN) begin
          r.ev = frd_pkg::EV_STDIN_BYTE;
          r.data = b;
          got = 1'b1;
        end
        content_left = content_left - 1'b1;
        if (content_left == 0) begin
          if (rec_kind == frd_pkg::KIND_BEGIN) begin
            begin_result(r);
            got = 1'b1;
          end
          rec_ph = (pad_left != 0) ? PH_PADDING : PH_HEADER;
        end
      end
      PH_PADDING: begin
        pad_left = pad_left - 1'b1;
        if (pad_left == 0) rec_ph = PH_HEADER;
      end
      default: begin
        case (hdr_idx)
          3'd1: rec_kind = b;
          3'd2: cur_id[15:8] = b;
          3'd3: cur_id[7:0] = b;
          3'd4: content_left[15:8] = b;
          3'd5: content_left[7:0] = b;
          3'd6: pad_left = b;
          default: ;
        endcase
        if (hdr_idx == 3'd7) begin
          hdr_idx = '0;
          begin_long = content_left >= frd_pkg::BEGIN_MIN_LEN;
          content_off = '0;
          if (rec_kind == frd_pkg::KIND_BEGIN) begin
            role_word = '0;
            flags_byte = '0;
          end
          if (content_left != 0) begin
            rec_ph = PH_CONTENT;
          end else begin
            if (rec_kind == frd_pkg::KIND_BEGIN) begin
              begin_result(r);
              got = 1'b1;
            end else if (rec_kind == frd_pkg::KIND_PARAMS) begin
              r.ev = frd_pkg::EV_PARAMS_END;
              r.pok = pair_st == PP_NAME_LEN;
              clear_pairs();
              got = 1'b1;
            end else if (rec_kind == frd_pkg::KIND_STDIN) begin
              r.ev = frd_pkg::EV_REQ_DONE;
              got = 1'b1;
            end
            rec_ph = (pad_left != 0) ? PH_PADDING : PH_HEADER;
          end
        end else begin
          hdr_idx = hdr_idx + 1'b1;
        end
      end
    endcase
    if (got) r.id = cur_id;
    else r = '0;
  endtask

  function automatic string describe(input decoded_ev_t r);
    return $sformatf({"ev=%0d data=%02h last=%b id=%04h name_len=%0d value_len=%0d",
                      " rok=%b keep=%b pok=%b spare=%02h"},
                     r.ev, r.data, r.last, r.id, r.name_len, r.value_len,
                     r.rok, r.keep, r.pok, r.spare);
  endfunction

  task automatic check_result();
    decoded_ev_t seen;
    decoded_ev_t want;
    seen.ev        = frd_pkg::frd_event_t'(out_tuser);
    seen.data      = out_tdata[7:0];
    seen.last      = out_tlast;
    seen.id        = out_tdata[23:8];
    seen.name_len  = out_tdata[54:24];
    seen.value_len = out_tdata[85:55];
    seen.rok       = out_tdata[86];
    seen.keep      = out_tdata[87];
    seen.pok       = out_tdata[88];
    seen.spare     = out_tdata[95:89];
    if (expected_events.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result with none expected: %s", $time, describe(seen));
    end else begin
      want = expected_events.pop_front();
      if (seen.ev !== want.ev || seen.data !== want.data || seen.last !== want.last ||
          seen.id !== want.id || seen.name_len !== want.name_len ||
          seen.value_len !== want.value_len || seen.rok !== want.rok ||
          seen.keep !== want.keep || seen.pok !== want.pok || seen.spare !== want.spare) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: event mismatch", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(seen));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_predictor();
      expected_events.delete();
      mismatches = 0;
      error_count <= 0;
      pending_count <= 0;
    end else begin
      // a result leaving at this edge belongs to an earlier byte
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        predict_step(in_tdata, has_ev, next_ev);
        if (has_ev) expected_events.push_back(next_ev);
      end
      error_count <= mismatches;
      pending_count <= expected_events.size();
    end
  end

endmodule

### test/tb_fastcgi_record_deframer_unit.sv
// testbench top for fastcgi_record_deframer_unit: builds fastcgi record streams,
// drives them with random gaps and stalls, and reports the verdict
// depends on frd_pkg, the deframer rtl and frd_event_checker
module tb_fastcgi_record_deframer_unit;

  localparam int STREAM_ITEMS   = 1400;  // request bytes in the whole stream, roughly
  localparam int LONG_HOLD      = 200;   // result side holdoff, forces input backpressure
  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int SETTLE_CYCLES  = 12;    // extra wait after the drain to catch stray results
  localparam int unsigned LW    = frd_pkg::LEN_W;

  // record types the block skips
  localparam logic [7:0] KIND_UNKNOWN_ZERO = 8'h00;
  localparam logic [7:0] KIND_ABORT        = 8'h02;
  localparam logic [7:0] KIND_UNKNOWN_MAX  = 8'hff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;      // [7:0] stream_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;             // [7:0] data_byte, [23:8] request_id,
                                      // [54:24] name_length, [85:55] value_length,
                                      // [86] responder_ok, [87] keep_connection,
                                      // [88] params_ok, [95:89] zero
  logic        out_tlast;             // last_of_field
  logic [2:0]  out_tuser;             // [2:0] event_res
  int          error_count;
  int          pending_count;

  // the whole request byte stream is built up front, then driven
  logic [7:0] stream_q[$];
  logic [7:0] body_q[$];    // content of the record being built
  logic [7:0] pairs_q[$];   // encoded name/value pairs waiting to be split into records
  int         hold_at = -1; // stream index where the result side starts its long holdoff
  bit         hold_req = 1'b0;

  fastcgi_record_deframer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  frd_event_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reset held low at the start, released once
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // mostly no padding, sometimes a little, rarely the widest
  function automatic logic [7:0] pick_pad();
    int unsigned r;
    r = $urandom_range(0, 39);
    if (r == 0) return 8'hff;
    if (r < 10) return 8'($urandom_range(1, 7));
    return 8'd0;
  endfunction

  // pair lengths: mostly short, some that need the four-byte form
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(0, 8);
    if (r < 19) return $urandom_range(9, 40);
    return $urandom_range(120, 135);
  endfunction

  // header (version and reserved are random, they are ignored), body, padding
  task automatic emit_record(input logic [7:0] kind, input logic [15:0] id,
                             input logic [7:0] pad);
    logic [15:0] len;
    len = 16'(body_q.size());
    stream_q.push_back(rand_byte());
    stream_q.push_back(kind);
    stream_q.push_back(id[15:8]);
    stream_q.push_back(id[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    stream_q.push_back(pad);
    stream_q.push_back(rand_byte());
    while (body_q.size() > 0) stream_q.push_back(body_q.pop_front());
    repeat (pad) stream_q.push_back(rand_byte());
  endtask

  // role, flags, then reserved bytes, cut to len
  task automatic put_begin_body(input logic [15:0] role, input logic [7:0] flags,
                                input int len);
    for (int k = 0; k < len; k++) begin
      case (k)
        0: body_q.push_back(role[15:8]);
        1: body_q.push_back(role[7:0]);
        2: body_q.push_back(flags);
        default: body_q.push_back(rand_byte());
      endcase
    end
  endtask

  // one-byte length below 128 unless wide is set, else four bytes with the top bit set
  task automatic add_len(input logic [LW-1:0] len, input bit wide);
    if (!wide && len < 128) begin
      pairs_q.push_back(len[7:0]);
    end else begin
      pairs_q.push_back({1'b1, len[30:24]});
      pairs_q.push_back(len[23:16]);
      pairs_q.push_back(len[15:8]);
      pairs_q.push_back(len[7:0]);
    end
  endtask

  task automatic add_pair(input int unsigned nlen, input int unsigned vlen,
                          input bit nwide, input bit vwide);
    add_len(LW'(nlen), nwide);
    add_len(LW'(vlen), vwide);
    repeat (nlen + vlen) pairs_q.push_back(rand_byte());
  endtask

  // pairs are split at random points into records of up to 24 bytes, then an empty
  // params record closes the stream
  task automatic emit_params(input logic [15:0] id);
    int chunk;
    while (pairs_q.size() > 0) begin
      chunk = $urandom_range(1, (pairs_q.size() < 24) ? pairs_q.size() : 24);
      repeat (chunk) body_q.push_back(pairs_q.pop_front());
      emit_record(frd_pkg::KIND_PARAMS, id, pick_pad());
    end
    emit_record(frd_pkg::KIND_PARAMS, id, pick_pad());
  endtask

  // record of a type that is skipped
  task automatic emit_noise();
    logic [7:0] kind;
    int n;
    do kind = rand_byte();
    while (kind == frd_pkg::KIND_BEGIN || kind == frd_pkg::KIND_PARAMS ||
           kind == frd_pkg::KIND_STDIN);
    n = $urandom_range(0, 10);
    repeat (n) body_q.push_back(rand_byte());
    emit_record(kind, {rand_byte(), rand_byte()}, pick_pad());
  endtask

  // begin, params, stdin; now and then a short begin body, a cut pair,
  // a huge declared length or a skipped record in between
  task automatic gen_request();
    logic [15:0] id;
    logic [15:0] role;
    logic [7:0]  flags;
    int n;
    int k;
    id = {rand_byte(), rand_byte()};
    role = ($urandom_range(0, 9) != 0) ? frd_pkg::ROLE_RESPONDER
                                       : {rand_byte(), rand_byte()};
    case ($urandom_range(0, 3))
      0: flags = 8'd0;
      1, 2: flags = frd_pkg::FLAG_KEEP;
      default: flags = rand_byte();
    endcase
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 11);
    put_begin_body(role, flags, n);
    emit_record(frd_pkg::KIND_BEGIN, id, pick_pad());
    if ($urandom_range(0, 4) == 0) emit_noise();

    n = $urandom_range(0, 4);
    repeat (n) add_pair(pick_len(), pick_len(), $urandom_range(0, 3) == 0,
                        $urandom_range(0, 3) == 0);
    case ($urandom_range(0, 11))
      0: begin
        // pair data cut short
        if (pairs_q.size() > 0) begin
          k = $urandom_range(1, pairs_q.size());
          repeat (k) pairs_q.delete(pairs_q.size() - 1);
        end
      end
      1: begin
        // random 31-bit length that the data never fills
        add_len(LW'($urandom), 1'b1);
        repeat ($urandom_range(0, 4)) pairs_q.push_back(rand_byte());
      end
      default: ;
    endcase
    emit_params(id);

    n = $urandom_range(0, 3);
    repeat (n) begin
      k = $urandom_range(1, 16);
      repeat (k) body_q.push_back(rand_byte());
      emit_record(frd_pkg::KIND_STDIN, id, pick_pad());
    end
    emit_record(frd_pkg::KIND_STDIN, id, pick_pad());
  endtask

  task automatic build_directed();
    // begin request with no content, highest id
    emit_record(frd_pkg::KIND_BEGIN, 16'hffff, 8'd0);
    // responder with keep-connection, id zero
    put_begin_body(frd_pkg::ROLE_RESPONDER, frd_pkg::FLAG_KEEP, 8);
    emit_record(frd_pkg::KIND_BEGIN, 16'h0000, 8'd0);
    // begin body shorter than eight bytes
    put_begin_body(frd_pkg::ROLE_RESPONDER, frd_pkg::FLAG_KEEP, 3);
    emit_record(frd_pkg::KIND_BEGIN, 16'h1234, 8'd1);
    // longer body, flags other than keep-connection
    put_begin_body(frd_pkg::ROLE_RESPONDER, 8'h02, 10);
    emit_record(frd_pkg::KIND_BEGIN, 16'h00ff, 8'd0);
    // role other than responder
    put_begin_body(16'h0100, frd_pkg::FLAG_KEEP, 8);
    emit_record(frd_pkg::KIND_BEGIN, 16'hff00, 8'd0);

    // short and four-byte lengths, empty names and values, largest short length
    add_pair(3, 2, 1'b0, 1'b0);
    add_pair(2, 5, 1'b1, 1'b1);
    add_pair(0, 0, 1'b0, 1'b0);
    add_pair(0, 3, 1'b0, 1'b1);
    add_pair(2, 0, 1'b1, 1'b0);
    add_pair(127, 1, 1'b0, 1'b0);
    emit_params(16'h0001);
    // lone name length, so params end off a pair boundary
    add_len(31'd5, 1'b0);
    emit_params(16'h0001);
    // all-ones four-byte length masked to 31 bits, data cut short
    add_len(31'h7fffffff, 1'b1);
    add_len(31'd0, 1'b0);
    repeat (3) pairs_q.push_back(rand_byte());
    emit_params(16'h0002);

    // stdin with the widest padding
    repeat (3) body_q.push_back(rand_byte());
    emit_record(frd_pkg::KIND_STDIN, 16'h0002, 8'hff);
    // long stdin body; the result side holds off while it streams in
    hold_at = stream_q.size() + 8;
    repeat (257) body_q.push_back(rand_byte());
    emit_record(frd_pkg::KIND_STDIN, 16'h0002, 8'd0);
    emit_record(frd_pkg::KIND_STDIN, 16'h0002, 8'd0);

    // skipped record types, with and without content and padding
    repeat (4) body_q.push_back(rand_byte());
    emit_record(KIND_UNKNOWN_MAX, 16'h0003, 8'd2);
    emit_record(KIND_UNKNOWN_ZERO, 16'h0003, 8'd0);
    emit_record(KIND_ABORT, 16'h0003, 8'd3);
  endtask

  // byte source: builds the stream, drives it with random gaps, then waits
  // for every expected event and gives the verdict
  initial begin : byte_source
    int gap;
    int calm;
    calm = 0;
    build_directed();
    // mostly well-formed requests with random content, some skipped records
    while (stream_q.size() < STREAM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) emit_noise();
      else gen_request();
    end

    wait (rst_n);
    @(posedge clk);
    foreach (stream_q[i]) begin
      if (i == hold_at) hold_req = 1'b1;
      // random gap before each item, with occasional back-to-back stretches
      if (calm > 0) begin
        calm--;
        gap = 0;
      end else begin
        gap = $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 60);
      end
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_tvalid <= 1'b1;
      in_tdata <= stream_q[i];
      @(posedge clk);
      while (!in_tready) @(posedge clk);
    end
    in_tvalid <= 1'b0;

    // drain, then wait SETTLE_CYCLES more to catch stray results
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result sink: random stalls per item, calm stretches, and one long holdoff
  // while the sender keeps offering so the block fills and stalls its input
  initial begin : result_sink
    int stall;
    int calm;
    bit held;
    calm = 0;
    held = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        stall = LONG_HOLD;
      end else if (calm > 0) begin
        calm--;
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
        if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 60);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // watchdog: too many cycles with no item moving on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
